[rtl/tlbf_pkg.sv]
// ----------------------------------------------------------------------------
// tlbf_pkg
// shared types, codes and constants of the translation lookaside buffer
// ----------------------------------------------------------------------------
package tlbf_pkg;

    localparam int ADDR_W  = 32;
    localparam int PID_W   = 16;
    localparam int FRAME_W = 20;
    localparam int PAGE_W  = 16;
    localparam int LIMIT_W = 5;

    localparam int MAX_ENTRIES_DEF = 16;
    localparam int DIV_RADIX_BITS  = 2;
    localparam int QUEUE_DEPTH     = 2;

    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // register indexes
    localparam logic [1:0] REG_PAGE_SIZE    = 2'd0;
    localparam logic [1:0] REG_ENTRIES      = 2'd1;
    localparam logic [1:0] REG_REPLACE_MODE = 2'd2;

    // register reset values
    localparam logic [PAGE_W-1:0]  PAGE_SIZE_RST = 16'd32;
    localparam logic [LIMIT_W-1:0] ENTRIES_RST   = 5'd16;

    // operation and mode codes
    localparam logic FUNC_LOOKUP = 1'b0;
    localparam logic FUNC_FILL   = 1'b1;
    localparam logic MODE_FIFO   = 1'b0;
    localparam logic MODE_LRU    = 1'b1;

    typedef struct packed {
        logic               func;
        logic [PID_W-1:0]   process_id;
        logic [ADDR_W-1:0]  logical_address;
        logic [ADDR_W-1:0]  fill_page;
        logic [FRAME_W-1:0] fill_frame;
    } tlb_in_t;

    typedef struct packed {
        logic               hit;
        logic [FRAME_W-1:0] frame_number;
        logic [ADDR_W-1:0]  page_number;
        logic [PAGE_W-1:0]  page_offset;
        logic               evicted;
    } tlb_out_t;

    // classified operation handed from front end to back end
    typedef struct packed {
        logic               is_fill;
        logic [PID_W-1:0]   process_id;
        logic [ADDR_W-1:0]  page;
        logic [PAGE_W-1:0]  offset;
        logic [FRAME_W-1:0] frame;
    } tlb_op_t;

    typedef struct packed {
        logic [PAGE_W-1:0]  page_size;
        logic [LIMIT_W-1:0] entries_in_use;
        logic               replace_mode;
    } tlb_cfg_t;

endpackage

[rtl/tlbf_queue.sv]
// ----------------------------------------------------------------------------
// tlbf_queue
// small register queue between pipeline parts
// ----------------------------------------------------------------------------
module tlbf_queue
    import tlbf_pkg::*;
#(
    parameter int WIDTH = 1,
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             wr_fire, rd_fire;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign wr_fire = wr_en && !full;
    assign rd_fire = rd_en && !empty;
    assign rd_data = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (wr_fire)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_fire)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CNT_W'(wr_fire) - CNT_W'(rd_fire);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_fire)
        begin
            slots_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

[rtl/tlbf_div.sv]
// ----------------------------------------------------------------------------
// tlbf_div
// iterative address divider, two quotient bits per cycle
// ----------------------------------------------------------------------------
module tlbf_div
    import tlbf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [ADDR_W-1:0] dividend,
    input  logic [PAGE_W-1:0] divisor,
    output logic              done,
    output logic [ADDR_W-1:0] quotient,
    output logic [PAGE_W-1:0] remainder
);

    localparam int STEPS = ADDR_W / DIV_RADIX_BITS;
    localparam int CNT_W = $clog2(STEPS);

    logic [ADDR_W-1:0] quo_reg, quo_next;
    logic [PAGE_W-1:0] rem_reg, rem_next;
    logic [PAGE_W-1:0] den_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              run_reg;
    logic              done_reg;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    function automatic logic [PAGE_W+ADDR_W-1:0] div_step(
        input logic [PAGE_W-1:0] r,
        input logic [ADDR_W-1:0] q,
        input logic [PAGE_W-1:0] d
    );
        logic [PAGE_W:0]   t;
        logic [PAGE_W:0]   diff;
        logic [PAGE_W-1:0] r_n;
        logic [ADDR_W-1:0] q_n;
        t    = {r, q[ADDR_W-1]};
        diff = t - {1'b0, d};
        q_n  = {q[ADDR_W-2:0], 1'b0};
        if (t >= {1'b0, d})
        begin
            r_n    = diff[PAGE_W-1:0];
            q_n[0] = 1'b1;
        end
        else
        begin
            r_n = t[PAGE_W-1:0];
        end
        return {r_n, q_n};
    endfunction

    always_comb
    begin
        quo_next = quo_reg;
        rem_next = rem_reg;
        for (int k = 0; k < DIV_RADIX_BITS; k++)
        begin
            {rem_next, quo_next} = div_step(rem_next, quo_next, den_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= run_reg && (cnt_reg == CNT_W'(STEPS - 1));
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(STEPS - 1))
                begin
                    run_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            // zero page size behaves as one
            den_reg <= (divisor == '0) ? PAGE_W'(1) : divisor;
        end
        else if (run_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

[rtl/tlbf_front.sv]
// ----------------------------------------------------------------------------
// tlbf_front
// accepts items, splits lookup addresses into page and offset, queues them
// ----------------------------------------------------------------------------
module tlbf_front
    import tlbf_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  tlb_cfg_t cfg,
    input  logic     push,
    input  tlb_in_t  request,
    output logic     full,
    input  logic     op_pop,
    output tlb_op_t  op,
    output logic     op_empty
);

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_DIV  = 2'd1;
    localparam logic [1:0] F_PUSH = 2'd2;

    logic [1:0]              state_reg, state_next;
    tlb_in_t                 item_reg;
    logic                    accept;
    logic                    div_start;
    logic                    div_done;
    logic [ADDR_W-1:0]       div_quo;
    logic [PAGE_W-1:0]       div_rem;
    tlb_op_t                 op_new;
    logic                    op_full;
    logic                    op_wr;
    logic [$bits(tlb_op_t)-1:0] op_bits;

    assign full      = (state_reg != F_IDLE);
    assign accept    = push && !full;
    assign div_start = accept && (request.func == FUNC_LOOKUP);
    assign op_wr     = (state_reg == F_PUSH);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    state_next = (request.func == FUNC_FILL) ? F_PUSH : F_DIV;
                end
            end
            F_DIV:
            begin
                if (div_done)
                begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (!op_full)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= request;
        end
    end

    always_comb
    begin
        op_new.is_fill    = (item_reg.func == FUNC_FILL);
        op_new.process_id = item_reg.process_id;
        op_new.frame      = item_reg.fill_frame;
        op_new.page       = op_new.is_fill ? item_reg.fill_page : div_quo;
        op_new.offset     = op_new.is_fill ? '0 : div_rem;
    end

    tlbf_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (request.logical_address),
        .divisor   (cfg.page_size),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    tlbf_queue #(
        .WIDTH ($bits(tlb_op_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_op_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (op_wr),
        .wr_data (op_new),
        .full    (op_full),
        .rd_en   (op_pop),
        .rd_data (op_bits),
        .empty   (op_empty)
    );

    assign op = op_bits;

endmodule

[rtl/tlbf_back.sv]
// ----------------------------------------------------------------------------
// tlbf_back
// entry store, scan sequencer, replacement and result queue
// ----------------------------------------------------------------------------
module tlbf_back
    import tlbf_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  tlb_cfg_t cfg,
    input  logic     op_empty,
    input  tlb_op_t  op,
    output logic     op_pop,
    input  logic     pop,
    output tlb_out_t result,
    output logic     empty
);

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int LIM_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_SCAN = 2'd1;
    localparam logic [1:0] B_TAIL = 2'd2;
    localparam logic [1:0] B_DONE = 2'd3;

    typedef struct packed {
        logic [PID_W-1:0]   pid;
        logic [ADDR_W-1:0]  page;
        logic [FRAME_W-1:0] frame;
    } tlbf_entry_t;

    logic [1:0]             state_reg, state_next;
    tlb_op_t                cur_reg;
    tlbf_entry_t            mem [MAX_ENTRIES];
    tlbf_entry_t            rd_reg;
    logic [IDX_W-1:0]       idx_reg;
    logic [IDX_W-1:0]       data_slot_reg;
    logic                   data_vld_reg;
    logic [MAX_ENTRIES-1:0] valid_reg;
    logic [IDX_W-1:0]       age_reg [MAX_ENTRIES];
    logic [CNT_W-1:0]       used_reg;
    logic                   best_found_reg;
    logic [IDX_W-1:0]       best_age_reg;
    logic [IDX_W-1:0]       best_slot_reg;
    logic [FRAME_W-1:0]     best_frame_reg;
    logic                   free_found_reg;
    logic [IDX_W-1:0]       free_slot_reg;

    logic                   start;
    logic                   issue_last;
    logic                   slot_valid;
    logic [IDX_W-1:0]       slot_age;
    logic                   cand;
    logic                   take_best;
    logic                   take_free;
    logic [LIM_W-1:0]       lim_raw, lim_max, lim;
    logic                   evict;
    logic [IDX_W-1:0]       fill_slot;
    logic                   finish;
    logic                   res_full;
    tlb_out_t               res_new;
    logic [$bits(tlb_out_t)-1:0] res_bits;

    assign start      = (state_reg == B_IDLE) && !op_empty;
    assign op_pop     = start;
    assign issue_last = (idx_reg == IDX_W'(MAX_ENTRIES - 1));
    assign finish     = (state_reg == B_DONE) && !res_full;

    // compare stage of the scan: one entry per cycle
    assign slot_valid = valid_reg[data_slot_reg];
    assign slot_age   = age_reg[data_slot_reg];
    assign cand       = cur_reg.is_fill ? slot_valid :
                        (slot_valid && rd_reg.pid == cur_reg.process_id &&
                         rd_reg.page == cur_reg.page);
    assign take_best  = data_vld_reg && cand && (!best_found_reg || slot_age > best_age_reg);
    assign take_free  = data_vld_reg && cur_reg.is_fill && !slot_valid && !free_found_reg;

    // entry limit clamped to one..capacity
    always_comb
    begin
        lim_raw = LIM_W'(cfg.entries_in_use);
        lim_max = LIM_W'(MAX_ENTRIES);
        if (lim_raw == '0)
        begin
            lim = LIM_W'(1);
        end
        else if (lim_raw > lim_max)
        begin
            lim = lim_max;
        end
        else
        begin
            lim = lim_raw;
        end
    end

    assign evict     = (LIM_W'(used_reg) >= lim) && best_found_reg;
    assign fill_slot = evict ? best_slot_reg : free_slot_reg;

    always_comb
    begin
        res_new.hit          = !cur_reg.is_fill && best_found_reg;
        res_new.frame_number = res_new.hit ? best_frame_reg : '0;
        res_new.page_number  = cur_reg.is_fill ? '0 : cur_reg.page;
        res_new.page_offset  = cur_reg.is_fill ? '0 : cur_reg.offset;
        res_new.evicted      = cur_reg.is_fill && evict;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (start)
                begin
                    state_next = B_SCAN;
                end
            end
            B_SCAN:
            begin
                if (issue_last)
                begin
                    state_next = B_TAIL;
                end
            end
            B_TAIL:
            begin
                state_next = B_DONE;
            end
            B_DONE:
            begin
                if (!res_full)
                begin
                    state_next = B_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= B_IDLE;
            data_vld_reg <= 1'b0;
            valid_reg    <= '0;
            used_reg     <= '0;
            for (int i = 0; i < MAX_ENTRIES; i++)
            begin
                age_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            data_vld_reg <= (state_reg == B_SCAN);
            if (finish && cur_reg.is_fill)
            begin
                for (int i = 0; i < MAX_ENTRIES; i++)
                begin
                    if (IDX_W'(i) == fill_slot)
                    begin
                        age_reg[i] <= '0;
                    end
                    else if (valid_reg[i])
                    begin
                        age_reg[i] <= age_reg[i] + 1'b1;
                    end
                end
                valid_reg[fill_slot] <= 1'b1;
                if (!evict)
                begin
                    used_reg <= used_reg + 1'b1;
                end
            end
            else if (finish && best_found_reg && cfg.replace_mode == MODE_LRU)
            begin
                for (int i = 0; i < MAX_ENTRIES; i++)
                begin
                    if (IDX_W'(i) == best_slot_reg)
                    begin
                        age_reg[i] <= '0;
                    end
                    else if (valid_reg[i] && age_reg[i] < best_age_reg)
                    begin
                        age_reg[i] <= age_reg[i] + 1'b1;
                    end
                end
            end
        end
    end

    // scan bookkeeping
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg        <= '0;
            best_found_reg <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else if (start)
        begin
            idx_reg        <= '0;
            best_found_reg <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == B_SCAN && !issue_last)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (take_best)
            begin
                best_found_reg <= 1'b1;
            end
            if (take_free)
            begin
                free_found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            cur_reg <= op;
        end
        if (take_best)
        begin
            best_age_reg   <= slot_age;
            best_slot_reg  <= data_slot_reg;
            best_frame_reg <= rd_reg.frame;
        end
        if (take_free)
        begin
            free_slot_reg <= data_slot_reg;
        end
        data_slot_reg <= idx_reg;
    end

    // entry store: one registered read a cycle, written by fills
    always_ff @(posedge clk)
    begin
        if (state_reg == B_SCAN)
        begin
            rd_reg <= mem[idx_reg];
        end
        if (finish && cur_reg.is_fill)
        begin
            mem[fill_slot] <= '{pid: cur_reg.process_id, page: cur_reg.page,
                                frame: cur_reg.frame};
        end
    end

    tlbf_queue #(
        .WIDTH ($bits(tlb_out_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (finish),
        .wr_data (res_new),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (res_bits),
        .empty   (empty)
    );

    assign result = res_bits;

endmodule

[rtl/tlb_translate_fifo_lru_top.sv]
// ----------------------------------------------------------------------------
// tlb_translate_fifo_lru_top
// Translation lookaside buffer keyed by process id and page number. A lookup
// splits the logical address into page and offset by the programmed page size
// (any value, zero acts as one) in a radix-4 divider, then the back end scans
// the entry store one slot a cycle and answers with hit and frame; a fill
// scans the same way to find a free slot or a victim (oldest inserted in FIFO
// mode, least recently used in LRU mode, where a hit also refreshes recency).
// The front end and the back end run on their own, joined by a two-deep
// operation queue, so the divider works on the next lookup while the back end
// scans. Each end takes a new item only once it is through with the last one.
// Valid bits clear at reset; there is no clearing pass.
// ----------------------------------------------------------------------------
module tlb_translate_fifo_lru_top
    import tlbf_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    // item side
    input  logic               push,
    input  tlb_in_t            request,
    output logic               full,
    // result side
    input  logic               pop,
    output tlb_out_t           result,
    output logic               empty,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    tlb_cfg_t   cfg_reg;
    logic       cfg_wr;
    logic [1:0] cfg_idx;
    tlb_op_t    op;
    logic       op_pop;
    logic       op_empty;

    // register file: a write transfer completes in the access phase
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.page_size      <= PAGE_SIZE_RST;
            cfg_reg.entries_in_use <= ENTRIES_RST;
            cfg_reg.replace_mode   <= MODE_FIFO;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_PAGE_SIZE:    cfg_reg.page_size      <= pwdata[PAGE_W-1:0];
                REG_ENTRIES:      cfg_reg.entries_in_use <= pwdata[LIMIT_W-1:0];
                REG_REPLACE_MODE: cfg_reg.replace_mode   <= pwdata[0];
                default:
                begin
                    // unmapped address, write ignored
                end
            endcase
        end
    end

    // read back, unmapped addresses read as zero
    always_comb
    begin
        case (cfg_idx)
            REG_PAGE_SIZE:    prdata = PDATA_W'(cfg_reg.page_size);
            REG_ENTRIES:      prdata = PDATA_W'(cfg_reg.entries_in_use);
            REG_REPLACE_MODE: prdata = PDATA_W'(cfg_reg.replace_mode);
            default:          prdata = '0;
        endcase
    end

    // front end: item transfer, address split, operation queue
    tlbf_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .push     (push),
        .request  (request),
        .full     (full),
        .op_pop   (op_pop),
        .op       (op),
        .op_empty (op_empty)
    );

    // back end: entry scan, replacement, result queue
    tlbf_back #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .op_empty (op_empty),
        .op       (op),
        .op_pop   (op_pop),
        .pop      (pop),
        .result   (result),
        .empty    (empty)
    );

endmodule

[bench/tlb_translate_fifo_lru_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlb_translate_fifo_lru_checker
// watches the request, result and register channels of the translation
// buffer, keeps its own copy of the entry store and the registers, predicts
// every result and compares each result transfer against the oldest one due
// ----------------------------------------------------------------------------
module tlb_translate_fifo_lru_checker
    import tlbf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  logic               full,
    input  tlb_in_t            request,
    input  logic               pop,
    input  logic               empty,
    input  tlb_out_t           result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    input  logic [PDATA_W-1:0] prdata,
    input  logic               pready,
    output int                 fail_count,
    output int                 pending
);

    localparam int SLOTS = MAX_ENTRIES_DEF;

    bit [PAGE_W-1:0]  cfg_page_size;
    bit [LIMIT_W-1:0] cfg_entries;
    bit               cfg_mode;

    bit               slot_valid [SLOTS];
    bit [PID_W-1:0]   slot_pid   [SLOTS];
    bit [ADDR_W-1:0]  slot_page  [SLOTS];
    bit [FRAME_W-1:0] slot_frame [SLOTS];
    int unsigned      slot_rank  [SLOTS];
    int unsigned      slots_used;

    tlb_out_t due_results[$];
    int       errors;

    function automatic void clear_tlb();
        cfg_page_size = PAGE_SIZE_RST;
        cfg_entries   = ENTRIES_RST;
        cfg_mode      = MODE_FIFO;
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_valid[i] = 1'b0;
            slot_rank[i]  = 0;
        end
        slots_used = 0;
        due_results.delete();
    endfunction

    // lookup or fill against the shadow store, updating ranks as the block does
    function automatic tlb_out_t predict_translation(tlb_in_t req);
        tlb_out_t    res;
        int unsigned div;
        int unsigned lim;
        int unsigned hit_rank;
        int          pick;
        bit          replaced;
        res  = '0;
        pick = -1;
        if (req.func == FUNC_LOOKUP)
        begin
            div = (cfg_page_size == 0) ? 1 : cfg_page_size;
            res.page_number = req.logical_address / div;
            res.page_offset = PAGE_W'(req.logical_address % div);
            // duplicates: the oldest matching entry answers
            for (int i = 0; i < SLOTS; i++)
                if (slot_valid[i] && slot_pid[i] == req.process_id
                    && slot_page[i] == res.page_number
                    && (pick < 0 || slot_rank[i] > slot_rank[pick]))
                    pick = i;
            if (pick >= 0)
            begin
                res.hit          = 1'b1;
                res.frame_number = slot_frame[pick];
                if (cfg_mode == MODE_LRU)
                begin
                    hit_rank = slot_rank[pick];
                    for (int i = 0; i < SLOTS; i++)
                        if (slot_valid[i] && slot_rank[i] < hit_rank)
                            slot_rank[i]++;
                    slot_rank[pick] = 0;
                end
            end
        end
        else
        begin
            lim = (cfg_entries == 0) ? 1 : ((cfg_entries > SLOTS) ? SLOTS : cfg_entries);
            replaced = 1'b0;
            if (slots_used >= lim)
            begin
                for (int i = 0; i < SLOTS; i++)
                    if (slot_valid[i] && (pick < 0 || slot_rank[i] > slot_rank[pick]))
                        pick = i;
                replaced = (pick >= 0);
            end
            if (pick < 0)
                for (int i = 0; i < SLOTS; i++)
                    if (pick < 0 && !slot_valid[i])
                        pick = i;
            if (pick < 0)
            begin
                pick = 0;
                for (int i = 1; i < SLOTS; i++)
                    if (slot_rank[i] > slot_rank[pick])
                        pick = i;
                replaced = 1'b1;
            end
            for (int i = 0; i < SLOTS; i++)
                if (i != pick && slot_valid[i])
                    slot_rank[i]++;
            if (!replaced)
                slots_used++;
            slot_valid[pick] = 1'b1;
            slot_pid[pick]   = req.process_id;
            slot_page[pick]  = req.fill_page;
            slot_frame[pick] = req.fill_frame;
            slot_rank[pick]  = 0;
            res.evicted      = replaced;
        end
        return res;
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want)
        begin
            $error("%s: expected %h, got %h", name, want, got);
            errors++;
        end
    endfunction

    function automatic logic [PDATA_W-1:0] reg_value(logic [1:0] idx);
        case (idx)
            REG_PAGE_SIZE:    return PDATA_W'(cfg_page_size);
            REG_ENTRIES:      return PDATA_W'(cfg_entries);
            REG_REPLACE_MODE: return PDATA_W'(cfg_mode);
            default:          return '0;
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        tlb_out_t want;
        if (!rst_n)
        begin
            clear_tlb();
            errors = 0;
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (psel && penable && pready)
            begin
                if (pwrite)
                begin
                    case (paddr[PADDR_W-1:2])
                        REG_PAGE_SIZE:    cfg_page_size = pwdata[PAGE_W-1:0];
                        REG_ENTRIES:      cfg_entries   = pwdata[LIMIT_W-1:0];
                        REG_REPLACE_MODE: cfg_mode      = pwdata[0];
                        default: ;
                    endcase
                end
                else
                    check_field("prdata", reg_value(paddr[PADDR_W-1:2]), prdata);
            end
            // results first: a transfer in the same cycle belongs to an older item
            if (pop && !empty)
            begin
                if (due_results.size() == 0)
                begin
                    $error("result transfer with no result due");
                    errors++;
                end
                else
                begin
                    want = due_results.pop_front();
                    check_field("hit",          want.hit,          result.hit);
                    check_field("frame_number", want.frame_number, result.frame_number);
                    check_field("page_number",  want.page_number,  result.page_number);
                    check_field("page_offset",  want.page_offset,  result.page_offset);
                    check_field("evicted",      want.evicted,      result.evicted);
                end
            end
            if (push && !full)
                due_results.push_back(predict_translation(request));
            fail_count <= errors;
            pending    <= due_results.size();
        end
    end

endmodule

[bench/tlb_translate_fifo_lru_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlb_translate_fifo_lru_top_tb
// stimulus and verdict for the translation buffer: a directed opening on the
// reset registers, then random phases under several register settings with
// bursty requests and a result side that stalls in some phases; a separate checker predicts
// and compares every transfer
// ----------------------------------------------------------------------------
module tlb_translate_fifo_lru_top_tb;
    import tlbf_pkg::*;

    // generous ceiling: a lookup costs a divider pass plus a full scan
    // in the worst case, on top of the longest stall and gap
    localparam int CYCLE_LIMIT      = 500000;
    localparam int DRAIN_CYCLES     = 60;
    localparam int RANDOM_PER_PHASE = 100;

    logic               clk;
    logic               rst_n   = 1'b0;
    logic               push    = 1'b0;
    tlb_in_t            request = '0;
    logic               pop     = 1'b0;
    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [PADDR_W-1:0] paddr   = '0;
    logic [PDATA_W-1:0] pwdata  = '0;
    logic               full;
    logic               empty;
    logic               pready;
    tlb_out_t           result;
    logic [PDATA_W-1:0] prdata;

    int fail_count;
    int pending;
    int cycles = 0;

    // receiver behaviour: 0 always ready, 1 coin toss, 2 long stalls
    int          rx_mode = 0;
    int unsigned hold_left = 0;

    // stimulus side knowledge of the page size, for building hitting addresses
    int unsigned    cur_div = PAGE_SIZE_RST;
    bit [PID_W-1:0] seen_pid[$];
    bit [ADDR_W-1:0] seen_page[$];

    tlb_translate_fifo_lru_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .request (request),
        .full    (full),
        .pop     (pop),
        .result  (result),
        .empty   (empty),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    tlb_translate_fifo_lru_checker u_watch (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .request    (request),
        .pop        (pop),
        .empty      (empty),
        .result     (result),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // reset once, released on a falling edge
    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tlb_translate_fifo_lru_top_tb: FAIL");
            $finish;
        end
    end

    // result side: its own stall pattern, changed per phase
    always @(negedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            case (rx_mode)
                0: pop <= 1'b1;
                1: pop <= 1'($urandom_range(1));
                default:
                begin
                    if (hold_left > 0)
                    begin
                        pop <= 1'b0;
                        hold_left--;
                    end
                    else
                    begin
                        pop <= 1'b1;
                        if ($urandom_range(9) == 0)
                            hold_left = $urandom_range(30, 5);
                    end
                end
            endcase
        end
    end

    // one request transfer; entered and left on a falling edge, push left high
    task automatic send(input tlb_in_t item);
        bit taken;
        push    <= 1'b1;
        request <= item;
        taken = 1'b0;
        while (!taken)
        begin
            @(posedge clk);
            taken = !full;
            @(negedge clk);
        end
    endtask

    // one register access: setup cycle, then access cycle until pready
    task automatic reg_access(input bit wr, input logic [1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // wait until every result has been taken, then let the pipeline settle
    task automatic quiesce();
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    function automatic tlb_in_t mk(logic fn, logic [PID_W-1:0] pid, logic [ADDR_W-1:0] addr,
                                   logic [ADDR_W-1:0] page, logic [FRAME_W-1:0] frame);
        tlb_in_t it;
        it.func            = fn;
        it.process_id      = pid;
        it.logical_address = addr;
        it.fill_page       = page;
        it.fill_frame      = frame;
        return it;
    endfunction

    // mostly fills and lookups that land on pages filled earlier, the rest noise
    function automatic tlb_in_t random_item();
        tlb_in_t     it;
        int unsigned pick;
        int unsigned k;
        bit [63:0]   addr64;
        it.func            = FUNC_LOOKUP;
        it.process_id      = PID_W'($urandom_range(3));
        it.logical_address = $urandom;
        it.fill_page       = $urandom;
        it.fill_frame      = FRAME_W'($urandom_range(20'hFFFFF));
        if ($urandom_range(9) == 0)
            it.process_id = PID_W'($urandom_range(16'hFFFF));
        pick = $urandom_range(99);
        if (pick < 35)
        begin
            it.func = FUNC_FILL;
            k = $urandom_range(99);
            if (k < 70)
                it.fill_page = $urandom_range(15);
            else if (k < 85)
                it.fill_page = 32'hFFFF_FFFF / cur_div;
            seen_pid.push_back(it.process_id);
            seen_page.push_back(it.fill_page);
            if (seen_page.size() > 24)
            begin
                void'(seen_pid.pop_front());
                void'(seen_page.pop_front());
            end
        end
        else if (pick < 85 && seen_page.size() > 0)
        begin
            k = $urandom_range(seen_page.size() - 1);
            it.process_id = seen_pid[k];
            // a near miss on the process id now and then
            if ($urandom_range(9) == 0)
                it.process_id ^= 16'h0001;
            addr64 = 64'(seen_page[k]) * cur_div + $urandom_range(cur_div - 1);
            if (addr64 <= 64'hFFFF_FFFF)
                it.logical_address = addr64[31:0];
        end
        else
        begin
            k = $urandom_range(7);
            if (k == 0)
                it.logical_address = '0;
            else if (k == 1)
                it.logical_address = '1;
        end
        return it;
    endfunction

    // random requests in bursts; a zero gap limit means no idling at all
    task automatic run_items(input int n, input int gap_max);
        int left;
        int burst;
        int gap;
        left = n;
        while (left > 0)
        begin
            burst = $urandom_range(12, 1);
            while (burst > 0 && left > 0)
            begin
                send(random_item());
                burst--;
                left--;
            end
            if (gap_max > 0)
            begin
                gap = $urandom_range(gap_max);
                if (gap > 0)
                begin
                    push <= 1'b0;
                    repeat (gap) @(negedge clk);
                end
            end
        end
        push <= 1'b0;
        @(negedge clk);
    endtask

    // registers change only with nothing in flight; each is read back too
    task automatic run_phase(input int unsigned ps, input int unsigned lim, input logic mode,
                             input int rx, input int gap_max);
        quiesce();
        reg_access(1'b1, REG_PAGE_SIZE, ps);
        reg_access(1'b1, REG_ENTRIES, lim);
        reg_access(1'b1, REG_REPLACE_MODE, {31'b0, mode});
        reg_access(1'b0, REG_PAGE_SIZE, '0);
        reg_access(1'b0, REG_ENTRIES, '0);
        reg_access(1'b0, REG_REPLACE_MODE, '0);
        cur_div = (ps[PAGE_W-1:0] == 0) ? 1 : ps[PAGE_W-1:0];
        rx_mode = rx;
        run_items(RANDOM_PER_PHASE, gap_max);
    endtask

    initial
    begin
        @(posedge rst_n);
        @(negedge clk);

        // directed opening on the reset registers: 32-byte pages, 16 entries, fifo
        send(mk(FUNC_LOOKUP, 16'h0000, 32'h0000_0000, '0, '0));          // empty buffer misses
        send(mk(FUNC_FILL,   16'h0000, '0, 32'h0000_0000, 20'h00000));
        send(mk(FUNC_LOOKUP, 16'h0000, 32'h0000_001F, '0, '0));          // hit, largest offset
        send(mk(FUNC_FILL,   16'hFFFF, '0, 32'h07FF_FFFF, 20'hFFFFF));
        send(mk(FUNC_LOOKUP, 16'hFFFF, 32'hFFFF_FFFF, '0, '0));          // top of address space
        send(mk(FUNC_FILL,   16'h0000, '0, 32'h0000_0000, 20'h12345));   // duplicate pid and page
        send(mk(FUNC_LOOKUP, 16'h0000, 32'h0000_0005, '0, '0));          // oldest duplicate answers
        send(mk(FUNC_LOOKUP, 16'h0001, 32'h0000_0000, '0, '0));          // other process misses
        // fill to the limit and one beyond, so the oldest entry goes
        for (int i = 0; i < 14; i++)
            send(mk(FUNC_FILL, 16'h0002, '0, ADDR_W'(i + 1), FRAME_W'(i)));
        send(mk(FUNC_LOOKUP, 16'h0000, 32'h0000_0000, '0, '0));          // only the newer duplicate left
        push <= 1'b0;
        @(negedge clk);

        // page size one, small table, lru, back to back on both sides
        run_phase(1, 4, MODE_LRU, 0, 0);
        // zero page size acts as one, zero limit acts as one, table already over it
        run_phase(0, 0, MODE_FIFO, 1, 25);
        // largest page size, limit beyond the table size
        run_phase(65535, 31, MODE_LRU, 2, 25);
        // non power of two divisor
        run_phase(3, 16, MODE_FIFO, 1, 6);
        // limit lowered well below the entries held
        run_phase(4096, 2, MODE_LRU, 2, 0);
        // back to fifo with the lru ranks carried over
        run_phase(7, 8, MODE_FIFO, 0, 25);
        run_phase(100, 5, MODE_LRU, 1, 10);
        run_phase(65534, 16, MODE_LRU, 0, 25);

        quiesce();
        if (fail_count == 0 && pending == 0)
            $display("tlb_translate_fifo_lru_top_tb: PASS");
        else
            $display("tlb_translate_fifo_lru_top_tb: FAIL");
        $finish;
    end

endmodule
